// File: src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int FIELD_W = 32;
  localparam int KIND_W  = 3;
  localparam int OCC_W   = 7;
  localparam int STAT_W  = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one write and one read port request for the element store
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr;
  } deq_mem_req_t;

  localparam word_t WORD_NEG_ONE = '1;
  localparam cnt_t  CNT_CAP      = CNT_W'(CAPACITY);
  localparam idx_t  IDX_LAST     = IDX_W'(CAPACITY - 1);

  // circular slot base + off, off below capacity
  function automatic idx_t slot_of(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) sum = sum - SUM_W'(CAPACITY);
    return sum[IDX_W-1:0];
  endfunction

  function automatic word_t to_word(logic signed [FIELD_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[WORD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(word_t w);
    logic [63:0] z;
    z = 64'(w);
    return z[FIELD_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(cnt_t c);
    logic [15:0] z;
    z = 16'(c);
    return z[OCC_W-1:0];
  endfunction

endpackage

// File: src/deq_store.sv
`timescale 1ns / 1ps

module deq_store import deq_pkg::*; (
  input  logic         clk,
  input  deq_mem_req_t req,
  output word_t        rd_data
);

  word_t mem_r [CAPACITY];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/double_ended_queue_core.sv
`timescale 1ns / 1ps

// channel | ports                                          | direction
// in      | in_valid/in_ready, in_kind, in_push_value       | request word in
// out     | out_valid/out_ready, out_popped_value,          | one result word
//         | out_front_value, out_back_value,               | per request
//         | out_occupancy, out_status                      |
//
// pushes, queries, pops on an empty queue and pops that leave at most one
// element write the result word at once; a pop that leaves two or more
// elements first reads the new front or back slot from the store in S_READ
// rst_n is synchronous and clears pointers and count; the store has
// no clearing pass since only written slots are ever read
// a finished result sits in the output register; a new request is taken in
// the same cycle that the held result leaves

module double_ended_queue_core import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [FIELD_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FIELD_W-1:0] out_popped_value,
  output logic signed [FIELD_W-1:0] out_front_value,
  output logic signed [FIELD_W-1:0] out_back_value,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic [STAT_W-1:0]        out_status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  // control state
  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  idx_t   front_r, front_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pend_front_r, pend_front_nxt;   // pending read refills front, else back

  // cached end elements, meaningful while the queue is not empty
  word_t  fv_r, fv_nxt;
  word_t  bv_r, bv_nxt;

  // output register
  logic [FIELD_W-1:0] pop_r, pop_nxt;
  logic [FIELD_W-1:0] ofront_r, ofront_nxt;
  logic [FIELD_W-1:0] oback_r, oback_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;

  deq_mem_req_t mem_req;
  word_t        rd_data;
  word_t        in_word;
  logic         fire;
  logic         need_rd;

  assign in_word  = to_word(in_push_value);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign fire     = in_valid && in_ready;

  deq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    front_nxt      = front_r;
    pend_front_nxt = pend_front_r;
    fv_nxt         = fv_r;
    bv_nxt         = bv_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    pop_nxt        = pop_r;
    ofront_nxt     = ofront_r;
    oback_nxt      = oback_r;
    occ_nxt        = occ_r;
    stat_nxt       = stat_r;
    mem_req        = '0;
    need_rd        = 1'b0;

    if (state_r == S_READ) begin
      // store data for the new end arrives now
      if (pend_front_r) begin
        fv_nxt     = rd_data;
        ofront_nxt = to_field(rd_data);
      end else begin
        bv_nxt    = rd_data;
        oback_nxt = to_field(rd_data);
      end
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end else if (fire) begin
      pop_nxt  = to_field(WORD_NEG_ONE);
      stat_nxt = ST_OK;
      case (in_kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (cnt_r >= CNT_CAP) begin
            stat_nxt = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = in_word;
            if (in_kind == KIND_PUSH_FRONT) begin
              front_nxt     = (front_r == '0) ? IDX_LAST : front_r - idx_t'(1);
              mem_req.waddr = front_nxt;
              fv_nxt        = in_word;
              if (cnt_r == '0) bv_nxt = in_word;
            end else begin
              mem_req.waddr = slot_of(front_r, cnt_r);
              bv_nxt        = in_word;
              if (cnt_r == '0) fv_nxt = in_word;
            end
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (cnt_r == '0) begin
            stat_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - cnt_t'(1);
            if (in_kind == KIND_POP_FRONT) begin
              pop_nxt        = to_field(fv_r);
              front_nxt      = slot_of(front_r, cnt_t'(1));
              pend_front_nxt = 1'b1;
              if (cnt_nxt == cnt_t'(1)) begin
                fv_nxt = bv_r;
              end else if (cnt_nxt != '0) begin
                need_rd       = 1'b1;
                mem_req.re    = 1'b1;
                mem_req.raddr = front_nxt;
              end
            end else begin
              pop_nxt        = to_field(bv_r);
              pend_front_nxt = 1'b0;
              if (cnt_nxt == cnt_t'(1)) begin
                bv_nxt = fv_r;
              end else if (cnt_nxt != '0) begin
                need_rd       = 1'b1;
                mem_req.re    = 1'b1;
                mem_req.raddr = slot_of(front_r, cnt_r - cnt_t'(2));
              end
            end
          end
        end
        default: begin
          // query and unused codes leave the queue alone
        end
      endcase

      // ends shown after the operation; a refilled end is overwritten next cycle
      ofront_nxt    = (cnt_nxt == '0) ? to_field(WORD_NEG_ONE) : to_field(fv_nxt);
      oback_nxt     = (cnt_nxt == '0) ? to_field(WORD_NEG_ONE) : to_field(bv_nxt);
      occ_nxt       = to_occ(cnt_nxt);
      out_valid_nxt = !need_rd;
      state_nxt     = need_rd ? S_READ : S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      front_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_front_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      front_r      <= front_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_front_r <= pend_front_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    fv_r     <= fv_nxt;
    bv_r     <= bv_nxt;
    pop_r    <= pop_nxt;
    ofront_r <= ofront_nxt;
    oback_r  <= oback_nxt;
    occ_r    <= occ_nxt;
    stat_r   <= stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = pop_r;
  assign out_front_value  = ofront_r;
  assign out_back_value   = oback_r;
  assign out_occupancy    = occ_r;
  assign out_status       = stat_r;

  // the output register is free while a store read is outstanding
  a_read_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r)
    else $error("result word held during store read");

  // a read always completes in the following cycle with a result word
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> (out_valid_r && state_r == S_IDLE))
    else $error("store read did not produce a result word");

  // count stays within capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("element count above capacity");

  // store reads and writes only happen for an accepted request
  a_mem_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we || mem_req.re) |-> fire)
    else $error("store access without an accepted request");

  // the count changes only for an accepted request
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cnt_r))
    else $error("element count changed without a request");

endmodule
